// ===== src/ctw_pkg.sv =====
// Shared types and constants for the crystal-to-world transform.
// No dependencies; imported by ctw_store, ctw_row, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package ctw_pkg;

  localparam int WORD_W         = 32;
  localparam int WORDS_PER_SLOT = 15;
  localparam int SLOT_W_BITS    = WORDS_PER_SLOT * WORD_W;
  localparam int ID_W           = 16;
  localparam int HOLE_W         = 14;
  localparam int CRYS_W         = 2;
  localparam int IDX_W          = 4;

  localparam logic [ID_W-1:0] HOLE_MASK    = 16'hfffc;
  localparam logic [ID_W-1:0] CRYSTAL_MASK = 16'h0003;
  localparam int              HOLE_SHIFT   = 2;

  // coefficient word layout inside a slot
  localparam int WORDS_PER_ROW = 4;
  localparam int OFFSET_BASE   = 12;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_HIT  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_HOLE    = 2'd1,
    ST_BAD_CRYSTAL = 2'd2
  } status_t;

  typedef logic [WORDS_PER_SLOT-1:0][WORD_W-1:0] slot_t;

  // request travelling down the pipeline alongside the datapath
  typedef struct packed {
    logic    valid;
    logic    hit;
    status_t status;
    logic    last;
  } tag_t;

  // write-back of one coefficient word into the slot held in stage 1
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  index;
    logic [WORD_W-1:0] value;
  } wr_req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] x;
    logic signed [WORD_W-1:0] y;
    logic signed [WORD_W-1:0] z;
    status_t                  status;
    logic                     last;
  } result_t;

endpackage

`default_nettype wire

// ===== src/ctw_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Read-first on a same-address collision. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ctw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/ctw_store.sv =====
// Coefficient store: one RAM row per crystal slot, read-modify-write for loads.
// Depends on ctw_pkg and ctw_ram.
`timescale 1ns / 1ps
`default_nettype none

module ctw_store #(
  parameter int SLOTS = 128
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    en,
  input  wire logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] rd_slot,
  input  wire ctw_pkg::wr_req_t                        wr,
  output ctw_pkg::slot_t                               slot_data
);
  import ctw_pkg::*;

  localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [SLOT_AW-1:0] cur_slot;
  logic               fwd_valid;
  logic [SLOT_AW-1:0] fwd_slot;
  slot_t              fwd_data;
  slot_t              rdata;
  slot_t              merged;
  logic               wen;

  ctw_ram #(
    .WIDTH (SLOT_W_BITS),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (wen),
    .waddr (cur_slot),
    .wdata (merged),
    .re    (en),
    .raddr (rd_slot),
    .rdata (rdata)
  );

  // the previous write landed on the same edge as this read, so the RAM
  // returned stale data for that slot
  assign slot_data = (fwd_valid && (fwd_slot == cur_slot)) ? fwd_data : rdata;
  assign wen       = en && wr.we;

  always_comb begin
    merged = slot_data;
    if (wr.index < IDX_W'(WORDS_PER_SLOT)) begin
      merged[wr.index] = wr.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (en) begin
      fwd_valid <= wr.we;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cur_slot <= rd_slot;
      fwd_slot <= cur_slot;
      fwd_data <= merged;
    end
  end

endmodule

`default_nettype wire

// ===== src/ctw_row.sv =====
// One output coordinate: three products, exact sum, floor shift, saturate.
// Depends on ctw_pkg. Two register stages; result is combinational off the last.
`timescale 1ns / 1ps
`default_nettype none

module ctw_row #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [ctw_pkg::WORD_W-1:0]   m0,
  input  wire logic signed [ctw_pkg::WORD_W-1:0]   m1,
  input  wire logic signed [ctw_pkg::WORD_W-1:0]   m2,
  input  wire logic signed [ctw_pkg::WORD_W-1:0]   m3,
  input  wire logic signed [ctw_pkg::WORD_W-1:0]   off,
  input  wire logic signed [ctw_pkg::WORD_W-1:0]   x,
  input  wire logic signed [ctw_pkg::WORD_W-1:0]   y,
  input  wire logic signed [ctw_pkg::WORD_W-1:0]   z,
  output logic      signed [ctw_pkg::WORD_W-1:0]   res
);
  import ctw_pkg::*;

  localparam int PROD_W = 2 * WORD_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int ADD_W  = WORD_W + 1;
  localparam int TOT_W  = SUM_W + 1;

  localparam logic signed [TOT_W-1:0] SAT_MAX = TOT_W'(2147483647);
  localparam logic signed [TOT_W-1:0] SAT_MIN = -TOT_W'(64'sd2147483648);

  logic signed [PROD_W-1:0] p0, p1, p2;
  logic signed [WORD_W-1:0] m3_q, off_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [ADD_W-1:0]  const_q;
  logic signed [SUM_W-1:0]  shifted;
  logic signed [TOT_W-1:0]  total;

  always_ff @(posedge clk) begin
    if (en) begin
      p0      <= m0 * x;
      p1      <= m1 * y;
      p2      <= m2 * z;
      m3_q    <= m3;
      off_q   <= off;
      sum_q   <= SUM_W'(p0) + SUM_W'(p1) + SUM_W'(p2);
      const_q <= ADD_W'(m3_q) + ADD_W'(off_q);
    end
  end

  // arithmetic shift of the exact sum floors towards minus infinity
  assign shifted = sum_q >>> FRAC_BITS;
  assign total   = TOT_W'(shifted) + TOT_W'(const_q);

  always_comb begin
    if (total > SAT_MAX) begin
      res = 32'sh7fffffff;
    end else if (total < SAT_MIN) begin
      res = 32'sh80000000;
    end else begin
      res = total[WORD_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== src/crystal_to_world_affine_transform.sv =====
// Top level of the crystal-to-world affine transform.
// Depends on ctw_pkg, ctw_store (with ctw_ram) and ctw_row.
//
// One request per clock, loads and hits alike; a hit's result passes the store
// read and the row registers into the two-entry output queue. The rate is
// set by the coefficient RAM, whose one row holds all fifteen words of a
// crystal slot: a hit reads its whole slot in one access, a load reads the
// row and writes it back merged as it leaves stage 1, with the last write
// forwarded so that back-to-back loads and hits to one slot see fresh data.
// The store is undefined until written and has no clearing pass; input is
// refused only while the output queue is full.
`timescale 1ns / 1ps
`default_nettype none

module crystal_to_world_affine_transform #(
  parameter int MAX_HOLE    = 31,
  parameter int MAX_CRYSTAL = 3,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  op,
  input  wire logic        [ctw_pkg::ID_W-1:0]       det_id,
  input  wire logic        [ctw_pkg::IDX_W-1:0]      coef_index,
  input  wire logic signed [ctw_pkg::WORD_W-1:0]     coef_value,
  input  wire logic signed [ctw_pkg::WORD_W-1:0]     x_in,
  input  wire logic signed [ctw_pkg::WORD_W-1:0]     y_in,
  input  wire logic signed [ctw_pkg::WORD_W-1:0]     z_in,
  input  wire logic                                  last_in,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed      [ctw_pkg::WORD_W-1:0]     x_out,
  output logic signed      [ctw_pkg::WORD_W-1:0]     y_out,
  output logic signed      [ctw_pkg::WORD_W-1:0]     z_out,
  output logic             [1:0]                     status,
  output logic                                       last_out
);
  import ctw_pkg::*;

  localparam int SLOTS   = (MAX_HOLE + 1) * (MAX_CRYSTAL + 1);
  localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // ---- stage 0: decode --------------------------------------------------
  logic [HOLE_W-1:0]  hole;
  logic [CRYS_W-1:0]  crystal;
  logic               hole_ok, crystal_ok;
  logic [31:0]        slot_full;
  logic [SLOT_AW-1:0] rd_slot;
  status_t            st0;
  logic               adv;

  assign hole       = HOLE_W'((det_id & HOLE_MASK) >> HOLE_SHIFT);
  assign crystal    = CRYS_W'(det_id & CRYSTAL_MASK);
  assign hole_ok    = 32'(hole) <= 32'(MAX_HOLE);
  assign crystal_ok = 32'(crystal) <= 32'(MAX_CRYSTAL);
  assign slot_full  = 32'(hole) * 32'(MAX_CRYSTAL + 1) + 32'(crystal);
  assign rd_slot    = (hole_ok && crystal_ok) ? slot_full[SLOT_AW-1:0] : '0;

  always_comb begin
    if (!hole_ok) begin
      st0 = ST_BAD_HOLE;
    end else if (!crystal_ok) begin
      st0 = ST_BAD_CRYSTAL;
    end else begin
      st0 = ST_OK;
    end
  end

  // ---- stage 1: slot data back from the store -----------------------------
  tag_t                     s1_tag, s2_tag, s3_tag;
  logic [IDX_W-1:0]         s1_idx;
  logic [WORD_W-1:0]        s1_val;
  logic signed [WORD_W-1:0] s1_x, s1_y, s1_z;
  wr_req_t                  wr;
  slot_t                    slot_data;

  assign wr.we    = s1_tag.valid && !s1_tag.hit && (s1_tag.status == ST_OK)
                    && (s1_idx < IDX_W'(WORDS_PER_SLOT));
  assign wr.index = s1_idx;
  assign wr.value = s1_val;

  ctw_store #(
    .SLOTS (SLOTS)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .rd_slot   (rd_slot),
    .wr        (wr),
    .slot_data (slot_data)
  );

  logic signed [WORD_W-1:0] row_res [3];

  for (genvar r = 0; r < 3; r++) begin : g_row
    ctw_row #(
      .FRAC_BITS (FRAC_BITS)
    ) u_row (
      .clk (clk),
      .en  (adv),
      .m0  (slot_data[r*WORDS_PER_ROW + 0]),
      .m1  (slot_data[r*WORDS_PER_ROW + 1]),
      .m2  (slot_data[r*WORDS_PER_ROW + 2]),
      .m3  (slot_data[r*WORDS_PER_ROW + 3]),
      .off (slot_data[OFFSET_BASE + r]),
      .x   (s1_x),
      .y   (s1_y),
      .z   (s1_z),
      .res (row_res[r])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag <= '0;
      s2_tag <= '0;
      s3_tag <= '0;
    end else if (adv) begin
      s1_tag.valid  <= in_valid;
      s1_tag.hit    <= (op == OP_HIT);
      s1_tag.status <= st0;
      s1_tag.last   <= last_in;
      s2_tag        <= s1_tag;
      s3_tag        <= s2_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_idx <= coef_index;
      s1_val <= coef_value;
      s1_x   <= x_in;
      s1_y   <= y_in;
      s1_z   <= z_in;
    end
  end

  // ---- output queue ---------------------------------------------------------
  result_t    q_data [2];
  logic       q_wptr, q_rptr;
  logic [1:0] q_count;
  logic       push, pop;
  result_t    res3;
  result_t    head;

  always_comb begin
    res3.status = s3_tag.status;
    res3.last   = s3_tag.last;
    if (s3_tag.status == ST_OK) begin
      res3.x = row_res[0];
      res3.y = row_res[1];
      res3.z = row_res[2];
    end else begin
      res3.x = '0;
      res3.y = '0;
      res3.z = '0;
    end
  end

  assign adv      = (q_count != 2'd2);
  assign in_stall = !adv;
  assign push     = adv && s3_tag.valid && s3_tag.hit;
  assign pop      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wptr  <= 1'b0;
      q_rptr  <= 1'b0;
      q_count <= 2'd0;
    end else begin
      if (push) begin
        q_wptr <= !q_wptr;
      end
      if (pop) begin
        q_rptr <= !q_rptr;
      end
      case ({push, pop})
        2'b10:   q_count <= q_count + 2'd1;
        2'b01:   q_count <= q_count - 2'd1;
        default: q_count <= q_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_data[q_wptr] <= res3;
    end
  end

  assign head      = q_data[q_rptr];
  assign out_valid = (q_count != 2'd0);
  assign x_out     = head.x;
  assign y_out     = head.y;
  assign z_out     = head.z;
  assign status    = head.status;
  assign last_out  = head.last;

`ifndef SYNTHESIS
  // refusing input only ever happens with results waiting
  a_stall_means_backlog: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output queue");

  // a held result is not dropped
  a_held_result_kept: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result vanished");

  // error results carry zero coordinates
  a_error_zeroed: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (x_out == '0) && (y_out == '0) && (z_out == '0))
    else $error("error result with non-zero coordinates");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_crystal_to_world_affine_transform.sv =====
// Self-checking testbench for crystal_to_world_affine_transform: loads and hits
// are predicted in place; world positions, status and last are compared on arrival.
// Depends on ctw_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_crystal_to_world_affine_transform;
  import ctw_pkg::*;

  localparam int MAX_HOLE    = 31;
  localparam int MAX_CRYSTAL = 3;
  localparam int FRAC_BITS   = 16;
  localparam int SLOT_COUNT  = (MAX_HOLE + 1) * (MAX_CRYSTAL + 1);
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [ID_W-1:0] FIRST_BAD_ID = ID_W'((MAX_HOLE + 1) << HOLE_SHIFT);
  localparam logic signed [127:0] SAT_HI = 128'sh7fff_ffff;
  localparam logic signed [127:0] SAT_LO = -128'sh8000_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic op = OP_LOAD;
  logic [ID_W-1:0] det_id = '0;
  logic [IDX_W-1:0] coef_index = '0;
  logic signed [WORD_W-1:0] coef_value = '0;
  logic signed [WORD_W-1:0] x_in = '0;
  logic signed [WORD_W-1:0] y_in = '0;
  logic signed [WORD_W-1:0] z_in = '0;
  logic last_in = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [WORD_W-1:0] x_out;
  logic signed [WORD_W-1:0] y_out;
  logic signed [WORD_W-1:0] z_out;
  logic [1:0] status;
  logic last_out;

  // shadow of the coefficient store, plus which words of each slot hold data
  logic [WORD_W-1:0] coef_mem [SLOT_COUNT][WORDS_PER_SLOT];
  logic [WORDS_PER_SLOT-1:0] words_loaded [SLOT_COUNT] = '{default: '0};
  int ready_slots[$];
  result_t world_hits_due[$];

  int mismatches = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  crystal_to_world_affine_transform #(
    .MAX_HOLE(MAX_HOLE),
    .MAX_CRYSTAL(MAX_CRYSTAL),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .det_id(det_id),
    .coef_index(coef_index),
    .coef_value(coef_value),
    .x_in(x_in),
    .y_in(y_in),
    .z_in(z_in),
    .last_in(last_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .x_out(x_out),
    .y_out(y_out),
    .z_out(z_out),
    .status(status),
    .last_out(last_out)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // one world coordinate: exact sum of products, floor shift, saturate
  function automatic logic [WORD_W-1:0] world_coord(input int slot, input int row,
      input logic signed [WORD_W-1:0] x, input logic signed [WORD_W-1:0] y,
      input logic signed [WORD_W-1:0] z);
    logic signed [127:0] acc;
    logic signed [127:0] term;
    logic signed [127:0] pos;
    logic signed [WORD_W-1:0] crd [3];
    crd[0] = x;
    crd[1] = y;
    crd[2] = z;
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      term = $signed(coef_mem[slot][row * WORDS_PER_ROW + k]);
      pos = crd[k];
      acc += term * pos;
    end
    term = $signed(coef_mem[slot][row * WORDS_PER_ROW + 3]);
    acc += term <<< FRAC_BITS;
    term = $signed(coef_mem[slot][OFFSET_BASE + row]);
    acc += term <<< FRAC_BITS;
    acc = acc >>> FRAC_BITS;
    if (acc > SAT_HI) return SAT_HI[WORD_W-1:0];
    if (acc < SAT_LO) return SAT_LO[WORD_W-1:0];
    return acc[WORD_W-1:0];
  endfunction

  function automatic result_t transform_hit(input logic [ID_W-1:0] id,
      input logic [WORD_W-1:0] x, input logic [WORD_W-1:0] y,
      input logic [WORD_W-1:0] z, input logic last);
    result_t res;
    int hole;
    int crystal;
    int slot;
    hole = (id & HOLE_MASK) >> HOLE_SHIFT;
    crystal = id & CRYSTAL_MASK;
    res.x = '0;
    res.y = '0;
    res.z = '0;
    res.last = last;
    res.status = ST_OK;
    if (hole > MAX_HOLE) begin
      res.status = ST_BAD_HOLE;
    end else if (crystal > MAX_CRYSTAL) begin
      res.status = ST_BAD_CRYSTAL;
    end else begin
      slot = hole * (MAX_CRYSTAL + 1) + crystal;
      res.x = world_coord(slot, 0, x, y, z);
      res.y = world_coord(slot, 1, x, y, z);
      res.z = world_coord(slot, 2, x, y, z);
    end
    return res;
  endfunction

  task automatic apply_request(input logic op_v, input logic [ID_W-1:0] id,
      input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] val,
      input logic [WORD_W-1:0] x, input logic [WORD_W-1:0] y,
      input logic [WORD_W-1:0] z, input logic last);
    int hole;
    int crystal;
    int slot;
    hole = (id & HOLE_MASK) >> HOLE_SHIFT;
    crystal = id & CRYSTAL_MASK;
    slot = hole * (MAX_CRYSTAL + 1) + crystal;
    if (op_v == OP_HIT) begin
      world_hits_due.push_back(transform_hit(id, x, y, z, last));
    end else if (hole <= MAX_HOLE && crystal <= MAX_CRYSTAL && idx < WORDS_PER_SLOT) begin
      coef_mem[slot][idx] = val;
      if (!(&words_loaded[slot])) begin
        words_loaded[slot][idx] = 1'b1;
        if (&words_loaded[slot]) ready_slots.push_back(slot);
      end
    end
  endtask

  task automatic send_request(input logic op_v, input logic [ID_W-1:0] id,
      input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] val,
      input logic [WORD_W-1:0] x, input logic [WORD_W-1:0] y,
      input logic [WORD_W-1:0] z, input logic last);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= op_v;
    det_id <= id;
    coef_index <= idx;
    coef_value <= val;
    x_in <= x;
    y_in <= y;
    z_in <= z;
    last_in <= last;
    do @(posedge clk); while (in_stall);
    apply_request(op_v, id, idx, val, x, y, z, last);
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    logic [WORD_W-1:0] r;
    r = $urandom();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2, 3: return r;
      default: return {{12{r[19]}}, r[19:0]};  // within about +-8.0, no saturation
    endcase
  endfunction

  function automatic logic [ID_W-1:0] bad_hole_id();
    return ID_W'($urandom_range(int'(FIRST_BAD_ID), 16'hffff));
  endfunction

  task automatic send_load(input logic [ID_W-1:0] id, input logic [IDX_W-1:0] idx,
      input logic [WORD_W-1:0] val);
    send_request(OP_LOAD, id, idx, val, $urandom(), $urandom(), $urandom(),
                 1'($urandom_range(0, 1)));
  endtask

  task automatic send_hit(input logic [ID_W-1:0] id, input logic [WORD_W-1:0] x,
      input logic [WORD_W-1:0] y, input logic [WORD_W-1:0] z, input logic last);
    send_request(OP_HIT, id, IDX_W'($urandom_range(0, 15)), $urandom(), x, y, z, last);
  endtask

  // Slot 0 gets saturating rows and a small row that needs floor rounding.
  // The crystal field has no spare codes, so a bad crystal status cannot occur.
  task automatic test_directed_extremes();
    logic [WORD_W-1:0] matrix [WORDS_PER_SLOT];
    matrix = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h0001_0000, 32'hffff_0000, 32'h0000_8000, 32'h0000_0001,
               32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff};
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < WORDS_PER_SLOT; i++) send_load('0, IDX_W'(i), matrix[i]);
    // unused word index and first hole past the limit: both dropped
    send_load('0, IDX_W'(WORDS_PER_SLOT), 32'h1234_5678);
    send_load(FIRST_BAD_ID, '0, 32'h5a5a_a5a5);
    send_hit('0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    send_hit('0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    send_hit('0, 32'h0000_0001, 32'h0000_0003, 32'hffff_ffff, 1'b0);
    send_hit('0, '0, '0, '0, 1'b1);
    send_hit(FIRST_BAD_ID, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
    send_hit(16'hffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 1'b1);
  endtask

  // Mostly hits on fully loaded slots; slots are filled as whole sequences,
  // with stray single-word rewrites, bad holes and dropped loads mixed in.
  task automatic test_random_traffic(input int n_items, input int send_pct,
      input int stall_pct);
    int sent;
    int pick;
    int slot;
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        if ($urandom_range(0, 1))
          send_load(ID_W'($urandom_range(0, SLOT_COUNT - 1)), IDX_W'(WORDS_PER_SLOT),
                    $urandom());
        else
          send_load(bad_hole_id(), IDX_W'($urandom_range(0, 15)), $urandom());
      end else if (pick < 10) begin
        send_hit(bad_hole_id(), rand_word(), rand_word(), rand_word(),
                 1'($urandom_range(0, 1)));
        sent++;
      end else if (pick < 22) begin
        send_load(ID_W'($urandom_range(0, SLOT_COUNT - 1)),
                  IDX_W'($urandom_range(0, WORDS_PER_SLOT - 1)), rand_word());
        sent++;
      end else if (pick < 24 || ready_slots.size() == 0) begin
        slot = $urandom_range(0, SLOT_COUNT - 1);
        for (int i = 0; i < WORDS_PER_SLOT; i++) send_load(ID_W'(slot), IDX_W'(i), rand_word());
        sent += WORDS_PER_SLOT;
      end else begin
        slot = ready_slots[$urandom_range(0, ready_slots.size() - 1)];
        send_hit(ID_W'(slot), rand_word(), rand_word(), rand_word(),
                 1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t due;
    if (!rst && out_valid && !out_stall) begin
      if (world_hits_due.size() == 0) begin
        $display("%0t: result with none expected: x %h y %h z %h status %0d last %0b",
                 $time, x_out, y_out, z_out, status, last_out);
        mismatches++;
      end else begin
        due = world_hits_due.pop_front();
        if (x_out !== due.x) begin
          $display("%0t: x_out expected %h actual %h", $time, due.x, x_out);
          mismatches++;
        end
        if (y_out !== due.y) begin
          $display("%0t: y_out expected %h actual %h", $time, due.y, y_out);
          mismatches++;
        end
        if (z_out !== due.z) begin
          $display("%0t: z_out expected %h actual %h", $time, due.z, z_out);
          mismatches++;
        end
        if (status !== due.status) begin
          $display("%0t: status expected %0d actual %0d", $time, due.status, status);
          mismatches++;
        end
        if (last_out !== due.last) begin
          $display("%0t: last_out expected %0b actual %0b", $time, due.last, last_out);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_extremes();
    test_random_traffic(600, 6, 63);
    test_random_traffic(600, 63, 6);
    test_random_traffic(600, 0, 0);
    @(negedge clk);
    in_valid <= 1'b0;
    while (world_hits_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
